/* hw/rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request modes, result
// status codes and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned ENTRY_W  = 64;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // Request operation codes; the unused code seven is a no-op
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request beat
    logic exec;   // run the captured operation
  } deq_cmd_t;

endpackage

/* hw/rtl/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for queue requests and results.
// ----------------------------------------------------------------------------
interface deq_req_if;
  import deq_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [ENTRY_W-1:0] entry_in;

  modport source (output valid, output mode, output entry_in, input ready);
  modport sink   (input valid, input mode, input entry_in, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  entry_out;
  logic                now_empty;

  modport source (output valid, output status, output entry_out, output now_empty,
                  input ready);
  modport sink   (input valid, input status, input entry_out, input now_empty,
                  output ready);
endinterface

/* hw/rtl/deq_ram.sv */
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: take a beat, run it through the datapath, hold the
// result until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshakes and commands
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.load  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.exec  = (state_q == S_EXEC);

`ifndef SYNTHESIS
  // An accepted beat is executed in the very next cycle
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("accepted beat not executed");

  // Execution always presents a result beat next
  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (out_valid_o && !in_ready_o))
    else $error("result beat missing after execution");
`endif

endmodule

/* hw/rtl/deq_dp.sv */
// ----------------------------------------------------------------------------
// deq_dp
// Queue datapath: ring pointers, entry RAM access and result registers.
// ----------------------------------------------------------------------------
module deq_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  deq_pkg::deq_cmd_t                cmd_i,
  input  logic [deq_pkg::MODE_W-1:0]       mode_i,
  input  logic [deq_pkg::ENTRY_W-1:0]      entry_in_i,
  output logic [deq_pkg::STATUS_W-1:0]     status_o,
  output logic [deq_pkg::ENTRY_W-1:0]      entry_out_o,
  output logic                             now_empty_o
);
  import deq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

  // Captured request
  logic [MODE_W-1:0]  mode_q;
  logic [ENTRY_W-1:0] entry_q;

  // Ring state
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Result registers
  logic [STATUS_W-1:0] status_q, status_d;
  logic                hit_q, hit_d;
  logic                now_empty_q;

  // RAM port
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Slot arithmetic: adds and subtracts with wrap compares
  logic             is_full, is_empty;
  logic [IDX_W-1:0] front_dec, front_inc, back_slot, last_slot;
  logic [SUM_W-1:0] back_sum, last_sum;

  assign is_full   = (count_q == FULL_CNT);
  assign is_empty  = (count_q == '0);
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign last_sum  = back_sum - 1'b1;
  assign back_slot = (back_sum >= CAP_SUM) ? IDX_W'(back_sum - CAP_SUM) : IDX_W'(back_sum);
  assign last_slot = (last_sum >= CAP_SUM) ? IDX_W'(last_sum - CAP_SUM) : IDX_W'(last_sum);

  // Operation decode
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = STAT_OK;
    hit_d    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = front_q;
    case (mode_q)
      MODE_PUSH_FRONT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          ram_we   = 1'b1;
          ram_addr = front_dec;
          front_d  = front_dec;
          count_d  = count_q + 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          ram_we   = 1'b1;
          ram_addr = back_slot;
          count_d  = count_q + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = front_q;
          hit_d    = 1'b1;
          if (mode_q == MODE_POP_FRONT) begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = last_slot;
          hit_d    = 1'b1;
          if (mode_q == MODE_POP_BACK) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      entry_q <= entry_in_i;
    end
  end

  // Ring pointers and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      status_q    <= STAT_OK;
      hit_q       <= 1'b0;
      now_empty_q <= 1'b1;
    end else if (cmd_i.exec) begin
      front_q     <= front_d;
      count_q     <= count_d;
      status_q    <= status_d;
      hit_q       <= hit_d;
      now_empty_q <= (count_d == '0);
    end
  end

  deq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we && cmd_i.exec),
    .re_i    (ram_re && cmd_i.exec),
    .addr_i  (ram_addr),
    .wdata_i (entry_q),
    .rdata_o (ram_rdata)
  );

  assign status_o    = status_q;
  assign entry_out_o = hit_q ? ram_rdata : '0;
  assign now_empty_o = now_empty_q;

`ifndef SYNTHESIS
  // Entry count never runs past the ring size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count exceeds capacity");

  // A refused push leaves the ring untouched
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_full &&
     (mode_q == MODE_PUSH_FRONT || mode_q == MODE_PUSH_BACK))
    |=> ($stable(count_q) && $stable(front_q) && status_q == STAT_FULL))
    else $error("refused push changed ring state");
`endif

endmodule

/* hw/rtl/double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of 64-bit entries in a ring of CAPACITY slots.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   mode[2:0], entry_in[63:0]
//   rsp_o    out  valid/ready   status[1:0], entry_out[63:0], now_empty
//
// Each request passes three steps: accept, execute (one RAM access and the
// pointer update), then the result beat. The single-port entry RAM with its
// registered read sets the execute step. Reset empties the queue at once;
// entry storage is not cleared. A stalled result holds the block, and no
// request is accepted until the result beat is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  deq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .mode_i      (req_i.mode),
    .entry_in_i  (req_i.entry_in),
    .status_o    (rsp_o.status),
    .entry_out_o (rsp_o.entry_out),
    .now_empty_o (rsp_o.now_empty)
  );

endmodule
